// ===== src/v3alu_pkg.sv =====
// Shared definitions for the three-component vector ALU.
// Holds the operation codes and the lane count; no dependencies.
`default_nettype none

package v3alu_pkg;

   localparam int LANES = 3;

   typedef enum logic [2:0] {
      OP_ADD    = 3'd0,
      OP_SUB    = 3'd1,
      OP_SCALE  = 3'd2,
      OP_CROSS  = 3'd3,
      OP_EMUL   = 3'd4,
      OP_DOT    = 3'd5,
      OP_LENGTH = 3'd6,
      OP_NORM   = 3'd7
   } op_type;

endpackage

`default_nettype wire

// ===== src/v3alu_lane.sv =====
// One multiplier lane of the vector ALU: selects two operand pairs by operation,
// multiplies them and registers their difference. Depends on v3alu_pkg.
`default_nettype none

module v3alu_lane
   import v3alu_pkg::*;
#(
   parameter int WORD_BITS = 32,
   parameter int LANE      = 0
) (
   input  logic                        clock,
   input  logic                        en,
   input  op_type                      op,
   input  logic [2:0][WORD_BITS-1:0]   u,
   input  logic [2:0][WORD_BITS-1:0]   v,
   input  logic [WORD_BITS-1:0]        scale,
   output logic [2*WORD_BITS:0]        diff
);

   localparam int W = WORD_BITS;
   localparam int J = (LANE + 1) % LANES;
   localparam int K = (LANE + 2) % LANES;

   logic signed [W-1:0]   a0, b0, a1, b1;
   logic signed [2*W-1:0] p0_ff, p1_ff;
   logic [2*W:0]          diff_ff;

   always_comb begin
      a0 = '0;
      b0 = '0;
      a1 = '0;
      b1 = '0;
      unique case (op) inside
         OP_SCALE: begin
            a0 = u[LANE];
            b0 = scale;
         end
         OP_CROSS: begin
            a0 = u[J];
            b0 = v[K];
            a1 = u[K];
            b1 = v[J];
         end
         OP_EMUL, OP_DOT: begin
            a0 = u[LANE];
            b0 = v[LANE];
         end
         OP_LENGTH, OP_NORM: begin
            a0 = u[LANE];
            b0 = u[LANE];
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p0_ff   <= a0 * b0;
         p1_ff   <= a1 * b1;
         diff_ff <= {p0_ff[2*W-1], p0_ff} - {p1_ff[2*W-1], p1_ff};
      end
   end

   assign diff = diff_ff;

endmodule

`default_nettype wire

// ===== src/v3alu_sqrt.sv =====
// Pipelined square root, one result bit per stage, rounded to nearest at the end.
// Carries a side payload and a valid bit alongside; no package dependencies.
`default_nettype none

module v3alu_sqrt #(
   parameter int WORD_BITS = 32,
   parameter int SIDE_BITS = 1
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   en,
   input  logic                   vld_in,
   input  logic [2*WORD_BITS-1:0] n,
   input  logic [SIDE_BITS-1:0]   side_in,
   output logic                   vld_out,
   output logic [WORD_BITS:0]     len,
   output logic [SIDE_BITS-1:0]   side_out
);

   localparam int W  = WORD_BITS;
   localparam int RB = W + 2;
   localparam int TB = W + 4;

   logic [RB-1:0]        rem_ff  [W];
   logic [W-1:0]         root_ff [W];
   logic [2*W-1:0]       rest_ff [W];
   logic [SIDE_BITS-1:0] side_ff [W+1];
   logic                 vld_ff  [W+1];
   logic [W:0]           len_ff;

   genvar k;
   for (k = 0; k < W; k++) begin : g_step
      logic [RB-1:0]        rem_prev;
      logic [W-1:0]         root_prev;
      logic [2*W-1:0]       rest_prev;
      logic [SIDE_BITS-1:0] side_prev;
      logic                 vld_prev;
      logic [TB-1:0]        cur, trial;

      if (k == 0) begin : g_first
         assign rem_prev  = '0;
         assign root_prev = '0;
         assign rest_prev = n;
         assign side_prev = side_in;
         assign vld_prev  = vld_in;
      end else begin : g_next
         assign rem_prev  = rem_ff[k-1];
         assign root_prev = root_ff[k-1];
         assign rest_prev = rest_ff[k-1];
         assign side_prev = side_ff[k-1];
         assign vld_prev  = vld_ff[k-1];
      end

      assign cur   = {rem_prev, rest_prev[2*W-1:2*W-2]};
      assign trial = {2'b00, root_prev, 2'b01};

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (en) begin
            vld_ff[k] <= vld_prev;
         end
         if (en) begin
            if (cur >= trial) begin
               rem_ff[k]  <= RB'(cur - trial);
               root_ff[k] <= {root_prev[W-2:0], 1'b1};
            end else begin
               rem_ff[k]  <= cur[RB-1:0];
               root_ff[k] <= {root_prev[W-2:0], 1'b0};
            end
            rest_ff[k] <= {rest_prev[2*W-3:0], 2'b00};
            side_ff[k] <= side_prev;
         end
      end
   end

   // A remainder above the root means the true root is past the halfway point.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[W] <= 1'b0;
      end else if (en) begin
         vld_ff[W] <= vld_ff[W-1];
      end
      if (en) begin
         side_ff[W] <= side_ff[W-1];
         if (rem_ff[W-1] > {2'b00, root_ff[W-1]}) begin
            len_ff <= {1'b0, root_ff[W-1]} + 1'b1;
         end else begin
            len_ff <= {1'b0, root_ff[W-1]};
         end
      end
   end

   assign vld_out  = vld_ff[W];
   assign len      = len_ff;
   assign side_out = side_ff[W];

endmodule

`default_nettype wire

// ===== src/v3alu_div.sv =====
// Pipelined restoring divider: three numerators over one shared divisor,
// one quotient bit per stage. Depends on v3alu_pkg for the lane count.
`default_nettype none

module v3alu_div
   import v3alu_pkg::*;
#(
   parameter int WORD_BITS = 32,
   parameter int FRAC_BITS = 16,
   parameter int SIDE_BITS = 1
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     en,
   input  logic                                     vld_in,
   input  logic [LANES-1:0][WORD_BITS+FRAC_BITS-1:0] num,
   input  logic [WORD_BITS:0]                       den,
   input  logic [SIDE_BITS-1:0]                     side_in,
   output logic                                     vld_out,
   output logic [LANES-1:0][WORD_BITS+FRAC_BITS-1:0] quo,
   output logic [SIDE_BITS-1:0]                     side_out
);

   localparam int NB = WORD_BITS + FRAC_BITS;
   localparam int DB = WORD_BITS + 1;

   logic [NB-1:0]        num_ff  [LANES];
   logic [DB-1:0]        rem_ff  [NB][LANES];
   logic [NB-1:0]        acc_ff  [NB][LANES];
   logic [DB-1:0]        den_ff  [NB+1];
   logic [SIDE_BITS-1:0] side_ff [NB+1];
   logic                 vld_ff  [NB+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= vld_in;
      end
      if (en) begin
         den_ff[0]  <= den;
         side_ff[0] <= side_in;
         for (int i = 0; i < LANES; i++) begin
            num_ff[i] <= num[i];
         end
      end
   end

   genvar k, i;
   for (k = 0; k < NB; k++) begin : g_step
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k+1] <= 1'b0;
         end else if (en) begin
            vld_ff[k+1] <= vld_ff[k];
         end
         if (en) begin
            den_ff[k+1]  <= den_ff[k];
            side_ff[k+1] <= side_ff[k];
         end
      end

      for (i = 0; i < LANES; i++) begin : g_lane
         logic [DB-1:0] rem_prev;
         logic [NB-1:0] acc_prev;
         logic [DB:0]   trial;
         logic          fits;

         if (k == 0) begin : g_first
            assign rem_prev = '0;
            assign acc_prev = num_ff[i];
         end else begin : g_next
            assign rem_prev = rem_ff[k-1][i];
            assign acc_prev = acc_ff[k-1][i];
         end

         assign trial = {rem_prev, acc_prev[NB-1]};
         assign fits  = (trial >= {1'b0, den_ff[k]});

         always_ff @(posedge clock) begin
            if (en) begin
               if (fits) begin
                  rem_ff[k][i] <= DB'(trial - {1'b0, den_ff[k]});
               end else begin
                  rem_ff[k][i] <= trial[DB-1:0];
               end
               acc_ff[k][i] <= {acc_prev[NB-2:0], fits};
            end
         end
      end
   end

   for (i = 0; i < LANES; i++) begin : g_quo
      assign quo[i] = acc_ff[NB-1][i];
   end

   assign vld_out  = vld_ff[NB];
   assign side_out = side_ff[NB];

endmodule

`default_nettype wire

// ===== src/vector3_alu.sv =====
// Top level of the three-component vector ALU in signed fixed point.
// Depends on v3alu_pkg, v3alu_lane, v3alu_sqrt and v3alu_div.
//
// The block takes one beat per cycle while req_tready is high and returns
// exactly one result beat for each, in order. Every operation takes the same
// path, which runs through the square root pipeline, retiring one root bit
// per stage, and the divider pipeline behind it, retiring one quotient bit
// per stage. Three multiplier lanes handle the components side by side and
// a merge stage sums, rounds and saturates their products. A two-entry
// output buffer lets the pipeline keep moving while the consumer stalls
// until both entries hold a result; req_tready falls only once that buffer
// is full.
`default_nettype none

module vector3_alu
   import v3alu_pkg::*;
#(
   parameter int FRAC_BITS = 16,
   parameter int WORD_BITS = 32
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_tvalid,
   output logic                                    req_tready,
   // u_x, u_y, u_z, v_x, v_y, v_z, scale
   input  logic [((7*WORD_BITS+7)/8)*8-1:0]        req_tdata,
   // operation
   input  logic [2:0]                              req_tuser,
   output logic                                    rsp_tvalid,
   input  logic                                    rsp_tready,
   // r_x, r_y, r_z, scalar_out
   output logic [((4*WORD_BITS+7)/8)*8-1:0]        rsp_tdata,
   // zero_length, overflow
   output logic [1:0]                              rsp_tuser
);

   localparam int W     = WORD_BITS;
   localparam int XW    = 2*W + 3;
   localparam int NB    = W + FRAC_BITS;
   localparam int OUT_W = ((4*W+7)/8)*8;

   localparam logic [W-1:0]  MAXW = {1'b0, {(W-1){1'b1}}};
   localparam logic [W-1:0]  MINW = {1'b1, {(W-1){1'b0}}};
   localparam logic [XW-1:0] HALF = XW'(1) << (FRAC_BITS - 1);

   typedef struct packed {
      op_type                 op;
      logic [2:0][W-1:0]      u;
      logic [2:0][W-1:0]      r;
      logic [W-1:0]           sc;
      logic                   zl;
      logic                   ovf;
   } side_type;

   localparam int SIDE_BITS = $bits(side_type);

   function automatic logic [W:0] sat_sum(input logic [W:0] x);
      logic [W:0] res;
      if (x[W] != x[W-1]) begin
         res = {1'b1, x[W] ? MINW : MAXW};
      end else begin
         res = {1'b0, x[W-1:0]};
      end
      return res;
   endfunction

   function automatic logic [W:0] rnd_sat(input logic [XW-1:0] x);
      logic [XW-1:0]  sh;
      logic [XW-W:0]  hi;
      logic [W:0]     res;
      sh = $signed(x + HALF) >>> FRAC_BITS;
      hi = sh[XW-1:W-1];
      if ((&hi) || (~|hi)) begin
         res = {1'b0, sh[W-1:0]};
      end else begin
         res = {1'b1, sh[XW-1] ? MINW : MAXW};
      end
      return res;
   endfunction

   function automatic logic [W:0] norm_sat(input logic [NB-1:0] q, input logic neg);
      logic [W:0] res;
      if (!neg) begin
         if (|q[NB-1:W-1]) begin
            res = {1'b1, MAXW};
         end else begin
            res = {1'b0, q[W-1:0]};
         end
      end else begin
         if ((|q[NB-1:W]) || (q[W-1] && (|q[W-2:0]))) begin
            res = {1'b1, MINW};
         end else begin
            res = {1'b0, ~q[W-1:0] + 1'b1};
         end
      end
      return res;
   endfunction

   logic en;

   // Input register.
   logic              a_vld_ff;
   op_type            a_op_ff;
   logic [2:0][W-1:0] a_u_ff, a_v_ff;
   logic [W-1:0]      a_s_ff;

   // Side registers beside the two lane stages.
   logic              b_vld_ff [2];
   op_type            b_op_ff  [2];
   logic [2:0][W-1:0] b_u_ff   [2];
   logic [2:0][W:0]   b_sum_ff [2];
   logic [2:0][W:0]   a_sum;

   // Merge stage.
   logic              c_vld_ff;
   op_type            c_op_ff;
   logic [2:0][W-1:0] c_u_ff;
   logic [2:0][W:0]   c_sum_ff;
   logic [2:0][2*W:0] c_d_ff;
   logic [XW-1:0]     c_tot_ff;
   logic [2:0][2*W:0] lane_d;

   // Round and saturate stage.
   logic              d_vld_ff;
   side_type          d_side_ff;
   logic [2*W-1:0]    d_n_ff;
   side_type          d_side_in;
   logic [2:0][W:0]   add_res, mul_res;
   logic [W:0]        dot_res;

   // Square root and divider.
   logic                   s_vld;
   logic [W:0]             s_len;
   logic [SIDE_BITS-1:0]   s_side_bits;
   side_type               s_side, e_side;
   logic [2:0][NB-1:0]     e_num;
   logic [2:0][W-1:0]      e_mag;
   logic                   q_vld;
   logic [2:0][NB-1:0]     q_quo;
   logic [SIDE_BITS-1:0]   q_side_bits;
   side_type               q_side;
   logic [2:0][W:0]        nrm_res;

   // Result and output buffer.
   logic [OUT_W-1:0] fin_data;
   logic [1:0]       fin_user;
   logic [2:0][W-1:0] fin_r;
   logic              fin_ovf;
   logic              rsp_vld_ff, skid_vld_ff;
   logic [OUT_W-1:0]  rsp_data_ff, skid_data_ff;
   logic [1:0]        rsp_user_ff, skid_user_ff;

   assign en         = ~skid_vld_ff;
   assign req_tready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
      end else if (en) begin
         a_vld_ff <= req_tvalid;
      end
      if (en) begin
         a_op_ff <= op_type'(req_tuser);
         for (int i = 0; i < 3; i++) begin
            a_u_ff[i] <= req_tdata[i*W +: W];
            a_v_ff[i] <= req_tdata[(i+3)*W +: W];
         end
         a_s_ff <= req_tdata[6*W +: W];
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (a_op_ff == OP_SUB) begin
            a_sum[i] = {a_u_ff[i][W-1], a_u_ff[i]} - {a_v_ff[i][W-1], a_v_ff[i]};
         end else begin
            a_sum[i] = {a_u_ff[i][W-1], a_u_ff[i]} + {a_v_ff[i][W-1], a_v_ff[i]};
         end
      end
   end

   genvar g;
   for (g = 0; g < LANES; g++) begin : g_lane
      v3alu_lane #(
         .WORD_BITS (W),
         .LANE      (g)
      ) u_lane (
         .clock (clock),
         .en    (en),
         .op    (a_op_ff),
         .u     (a_u_ff),
         .v     (a_v_ff),
         .scale (a_s_ff),
         .diff  (lane_d[g])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_vld_ff[0] <= 1'b0;
         b_vld_ff[1] <= 1'b0;
         c_vld_ff    <= 1'b0;
         d_vld_ff    <= 1'b0;
      end else if (en) begin
         b_vld_ff[0] <= a_vld_ff;
         b_vld_ff[1] <= b_vld_ff[0];
         c_vld_ff    <= b_vld_ff[1];
         d_vld_ff    <= c_vld_ff;
      end
      if (en) begin
         b_op_ff[0]  <= a_op_ff;
         b_u_ff[0]   <= a_u_ff;
         b_sum_ff[0] <= a_sum;
         b_op_ff[1]  <= b_op_ff[0];
         b_u_ff[1]   <= b_u_ff[0];
         b_sum_ff[1] <= b_sum_ff[0];
         c_op_ff     <= b_op_ff[1];
         c_u_ff      <= b_u_ff[1];
         c_sum_ff    <= b_sum_ff[1];
         c_d_ff      <= lane_d;
         c_tot_ff    <= {{2{lane_d[0][2*W]}}, lane_d[0]}
                      + {{2{lane_d[1][2*W]}}, lane_d[1]}
                      + {{2{lane_d[2][2*W]}}, lane_d[2]};
         d_side_ff   <= d_side_in;
         d_n_ff      <= c_tot_ff[2*W-1:0];
      end
   end

   for (g = 0; g < 3; g++) begin : g_merge
      assign add_res[g] = sat_sum(c_sum_ff[g]);
      assign mul_res[g] = rnd_sat({{2{c_d_ff[g][2*W]}}, c_d_ff[g]});
   end
   assign dot_res = rnd_sat(c_tot_ff);

   always_comb begin
      d_side_in    = '0;
      d_side_in.op = c_op_ff;
      d_side_in.u  = c_u_ff;
      unique case (c_op_ff) inside
         OP_ADD, OP_SUB: begin
            for (int i = 0; i < 3; i++) begin
               d_side_in.r[i] = add_res[i][W-1:0];
            end
            d_side_in.ovf = add_res[0][W] | add_res[1][W] | add_res[2][W];
         end
         OP_SCALE, OP_CROSS, OP_EMUL: begin
            for (int i = 0; i < 3; i++) begin
               d_side_in.r[i] = mul_res[i][W-1:0];
            end
            d_side_in.ovf = mul_res[0][W] | mul_res[1][W] | mul_res[2][W];
         end
         OP_DOT: begin
            d_side_in.sc  = dot_res[W-1:0];
            d_side_in.ovf = dot_res[W];
         end
         default: begin
         end
      endcase
   end

   v3alu_sqrt #(
      .WORD_BITS (W),
      .SIDE_BITS (SIDE_BITS)
   ) u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .vld_in   (d_vld_ff),
      .n        (d_n_ff),
      .side_in  (d_side_ff),
      .vld_out  (s_vld),
      .len      (s_len),
      .side_out (s_side_bits)
   );

   assign s_side = side_type'(s_side_bits);

   always_comb begin
      e_side = s_side;
      if (s_side.op == OP_LENGTH) begin
         if (|s_len[W:W-1]) begin
            e_side.sc  = MAXW;
            e_side.ovf = 1'b1;
         end else begin
            e_side.sc = s_len[W-1:0];
         end
      end
      if (s_side.op == OP_NORM) begin
         e_side.zl = (s_len == '0);
      end
      for (int i = 0; i < 3; i++) begin
         e_mag[i] = s_side.u[i][W-1] ? (~s_side.u[i] + 1'b1) : s_side.u[i];
         e_num[i] = {e_mag[i], {FRAC_BITS{1'b0}}} + NB'(s_len[W:1]);
      end
   end

   v3alu_div #(
      .WORD_BITS (W),
      .FRAC_BITS (FRAC_BITS),
      .SIDE_BITS (SIDE_BITS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .vld_in   (s_vld),
      .num      (e_num),
      .den      (s_len),
      .side_in  (e_side),
      .vld_out  (q_vld),
      .quo      (q_quo),
      .side_out (q_side_bits)
   );

   assign q_side = side_type'(q_side_bits);

   for (g = 0; g < 3; g++) begin : g_norm
      assign nrm_res[g] = norm_sat(q_quo[g], q_side.u[g][W-1]);
   end

   always_comb begin
      fin_r   = q_side.r;
      fin_ovf = q_side.ovf;
      if (q_side.op == OP_NORM) begin
         if (q_side.zl) begin
            fin_r = q_side.u;
         end else begin
            for (int i = 0; i < 3; i++) begin
               fin_r[i] = nrm_res[i][W-1:0];
            end
            fin_ovf = nrm_res[0][W] | nrm_res[1][W] | nrm_res[2][W];
         end
      end
      fin_data = OUT_W'({q_side.sc, fin_r[2], fin_r[1], fin_r[0]});
      fin_user = {fin_ovf, q_side.zl};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else if (rsp_tready || !rsp_vld_ff) begin
         rsp_vld_ff  <= skid_vld_ff | (en & q_vld);
         skid_vld_ff <= 1'b0;
      end else if (en && q_vld) begin
         skid_vld_ff <= 1'b1;
      end
      if (rsp_tready || !rsp_vld_ff) begin
         rsp_data_ff <= skid_vld_ff ? skid_data_ff : fin_data;
         rsp_user_ff <= skid_vld_ff ? skid_user_ff : fin_user;
      end else if (en && q_vld) begin
         skid_data_ff <= fin_data;
         skid_user_ff <= fin_user;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

`default_nettype wire
